[sv/mrte_pkg.sv]
`timescale 1ns / 1ps

package mrte_pkg;

  // Default table depth.
  localparam int TableEntriesDef = 32;

  // Field widths.
  localparam int AddrW  = 32;
  localparam int SeqW   = 32;
  localparam int HopsW  = 8;
  localparam int IfaceW = 4;
  localparam int TimeW  = 48;
  localparam int FlagW  = 3;

  // Flag bit positions.
  localparam int FlValid  = 0;
  localparam int FlSeqOk  = 1;
  localparam int FlStatic = 2;

  localparam logic [31:0] TimeoutReset = 32'd3000;

  typedef enum logic [2:0] {
    REQ_UPDATE = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_STATIC = 3'd3,
    REQ_SWEEP  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LIFE_ONLY = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NBR_BRK  = 2'd1,
    EV_EXPIRED  = 2'd2,
    EV_REMOVED  = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_SWEEP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FULL,
    WR_LIFE,
    WR_FREE
  } wr_op_t;

  // Write command broadcast along the row of cells.
  typedef struct packed {
    wr_op_t              op;
    logic [AddrW-1:0]    dest;
    logic [AddrW-1:0]    hop;
    logic [SeqW-1:0]     seq;
    logic [HopsW-1:0]    hops;
    logic [IfaceW-1:0]   iface;
    logic [TimeW-1:0]    expiry;
    logic [FlagW-1:0]    flags;
  } cell_wr_t;

  // Contents of one cell.
  typedef struct packed {
    logic                used;
    logic [AddrW-1:0]    dest;
    logic [AddrW-1:0]    hop;
    logic [SeqW-1:0]     seq;
    logic [HopsW-1:0]    hops;
    logic [IfaceW-1:0]   iface;
    logic [TimeW-1:0]    expiry;
    logic [FlagW-1:0]    flags;
  } cell_data_t;

  // Priority chain handed from each cell to the next.
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } chain_t;

endpackage

[sv/mesh_route_table_engine_top.sv]
`timescale 1ns / 1ps

// Route table held in a row of TABLE_ENTRIES cells, one route per cell. A request
// beat is taken when start is high and busy is low; busy then stays high until the
// request is finished. Update, lookup, delete and add static pass through the EXEC
// and RESP states and give their single result beat, registered as RESP ends. When
// the route is not found, the table is full or the request type is unknown, RESP
// is skipped and the result beat is registered as EXEC ends. An expiry sweep
// visits one cell per cycle in the SWEEP state, then passes through FIN to idle.
// It gives one beat per expired route as the sweep passes it, and a closing beat
// with last set, registered as FIN ends. Each result beat is on the out_ ports for
// one cycle with out_strobe high; the receiver cannot stall it.
// The timeout register is always ready and should be written only while busy is low.
module mesh_route_table_engine_top #(
  parameter int TABLE_ENTRIES = mrte_pkg::TableEntriesDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic [31:0]                   in_dst_addr,
  input  logic [31:0]                   in_relay_addr,
  input  logic [7:0]                    in_hop_count,
  input  logic [31:0]                   in_seq_num,
  input  logic [3:0]                    in_iface,
  input  logic [47:0]                   in_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [1:0]                    out_event_res,
  output logic [31:0]                   out_route_addr,
  output logic [31:0]                   out_route_relay,
  output logic [7:0]                    out_route_hops,
  output logic [31:0]                   out_route_seq,
  output logic [3:0]                    out_route_iface,
  output logic                          out_route_is_valid,
  output logic                          out_last
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  mrte_pkg::state_t      state_r, state_nxt;
  logic [2:0]            req_r;
  logic [31:0]           addr_r, nh_r, seq_r;
  logic [7:0]            hc_r;
  logic [3:0]            ifc_r;
  logic [47:0]           now_r;
  logic [31:0]           timeout_r;
  logic [IdxW-1:0]       idx_r, idx_nxt;
  logic [IdxW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]            rsp_status_r, rsp_status_nxt;

  logic                  o_strobe_r, o_strobe_nxt;
  logic [1:0]            o_status_r, o_status_nxt;
  logic [1:0]            o_event_r, o_event_nxt;
  logic [31:0]           o_addr_r, o_addr_nxt;
  logic [31:0]           o_nh_r, o_nh_nxt;
  logic [7:0]            o_hops_r, o_hops_nxt;
  logic [31:0]           o_seq_r, o_seq_nxt;
  logic [3:0]            o_iface_r, o_iface_nxt;
  logic                  o_valid_r, o_valid_nxt;
  logic                  o_last_r, o_last_nxt;

  mrte_pkg::cell_wr_t    wr;
  logic [IdxW-1:0]       wr_idx;
  mrte_pkg::chain_t      chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] hit_sel, free_sel;
  mrte_pkg::cell_data_t  cd [TABLE_ENTRIES];
  mrte_pkg::cell_data_t  rd;
  logic [IdxW-1:0]       hit_idx, free_idx, rd_idx;
  logic                  any_hit, any_free;
  logic [48:0]           life_sum;
  logic [47:0]           life;
  logic [31:0]           seq_diff;
  logic                  take;
  logic                  expired;

  assign busy      = (state_r != mrte_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Row of cells with the priority chain running through it.
  assign chain[0] = '{hit_found: 1'b0, free_found: 1'b0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mrte_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key       (addr_r),
      .wr        (wr),
      .sel       (wr_idx == IdxW'(g)),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hit_sel   (hit_sel[g]),
      .free_sel  (free_sel[g]),
      .data      (cd[g])
    );
  end

  assign any_hit  = chain[TABLE_ENTRIES].hit_found;
  assign any_free = chain[TABLE_ENTRIES].free_found;

  // One-hot claims to indexes.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_sel[i]) hit_idx = hit_idx | IdxW'(i);
      if (free_sel[i]) free_idx = free_idx | IdxW'(i);
    end
  end

  // Read port over the row.
  always_comb begin
    case (state_r)
      mrte_pkg::S_EXEC:  rd_idx = hit_idx;
      mrte_pkg::S_SWEEP: rd_idx = cnt_r;
      default:           rd_idx = idx_r;
    endcase
  end
  assign rd = cd[rd_idx];

  // Lifetime with saturation and the replace decision.
  assign life_sum = {1'b0, now_r} + {17'd0, timeout_r};
  assign life     = life_sum[48] ? {48{1'b1}} : life_sum[47:0];
  assign seq_diff = seq_r - rd.seq;
  assign take = !any_hit || !rd.flags[mrte_pkg::FlValid] || !rd.flags[mrte_pkg::FlSeqOk] ||
                (seq_diff != 32'd0 && !seq_diff[31]) ||
                (seq_r == rd.seq && hc_r < rd.hops);
  assign expired = rd.used && !rd.flags[mrte_pkg::FlStatic] && (rd.expiry < now_r);

  // Request sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    rsp_status_nxt = rsp_status_r;
    wr             = '{op: mrte_pkg::WR_NONE, dest: addr_r, hop: nh_r, seq: seq_r,
                       hops: hc_r, iface: ifc_r, expiry: life, flags: '0};
    wr_idx         = hit_idx;
    o_strobe_nxt   = 1'b0;
    o_status_nxt   = mrte_pkg::ST_OK;
    o_event_nxt    = mrte_pkg::EV_NONE;
    o_addr_nxt     = '0;
    o_nh_nxt       = '0;
    o_hops_nxt     = '0;
    o_seq_nxt      = '0;
    o_iface_nxt    = '0;
    o_valid_nxt    = 1'b0;
    o_last_nxt     = 1'b0;
    unique case (state_r)
      mrte_pkg::S_IDLE: begin
        if (start) state_nxt = mrte_pkg::S_EXEC;
      end
      mrte_pkg::S_EXEC: begin
        state_nxt = mrte_pkg::S_RESP;
        idx_nxt   = hit_idx;
        case (req_r) inside
          mrte_pkg::REQ_UPDATE: begin
            if (any_hit) begin
              if (take) begin
                wr.op    = mrte_pkg::WR_FULL;
                wr.flags = 3'b011 | (rd.flags & 3'b100);
                rsp_status_nxt = mrte_pkg::ST_OK;
              end else begin
                wr.op    = mrte_pkg::WR_LIFE;
                rsp_status_nxt = mrte_pkg::ST_LIFE_ONLY;
              end
            end else if (any_free) begin
              wr.op    = mrte_pkg::WR_FULL;
              wr.flags = 3'b011;
              wr_idx   = free_idx;
              idx_nxt  = free_idx;
              rsp_status_nxt = mrte_pkg::ST_OK;
            end else begin
              state_nxt    = mrte_pkg::S_IDLE;
              o_strobe_nxt = 1'b1;
              o_status_nxt = mrte_pkg::ST_FULL;
              o_addr_nxt   = addr_r;
              o_last_nxt   = 1'b1;
            end
          end
          mrte_pkg::REQ_LOOKUP, mrte_pkg::REQ_DELETE: begin
            if (any_hit) begin
              rsp_status_nxt = mrte_pkg::ST_OK;
              if (req_r == mrte_pkg::REQ_DELETE) wr.op = mrte_pkg::WR_FREE;
            end else begin
              state_nxt    = mrte_pkg::S_IDLE;
              o_strobe_nxt = 1'b1;
              o_status_nxt = mrte_pkg::ST_NOT_FOUND;
              o_addr_nxt   = addr_r;
              o_last_nxt   = 1'b1;
            end
          end
          mrte_pkg::REQ_STATIC: begin
            if (any_hit || any_free) begin
              wr.op     = mrte_pkg::WR_FULL;
              wr.hop    = addr_r;
              wr.seq    = 32'd1;
              wr.hops   = '0;
              wr.expiry = {48{1'b1}};
              wr.flags  = 3'b111;
              if (!any_hit) begin
                wr_idx  = free_idx;
                idx_nxt = free_idx;
              end
              rsp_status_nxt = mrte_pkg::ST_OK;
            end else begin
              state_nxt    = mrte_pkg::S_IDLE;
              o_strobe_nxt = 1'b1;
              o_status_nxt = mrte_pkg::ST_FULL;
              o_addr_nxt   = addr_r;
              o_last_nxt   = 1'b1;
            end
          end
          mrte_pkg::REQ_SWEEP: begin
            state_nxt = mrte_pkg::S_SWEEP;
            cnt_nxt   = '0;
          end
          default: begin
            state_nxt    = mrte_pkg::S_IDLE;
            o_strobe_nxt = 1'b1;
            o_status_nxt = mrte_pkg::ST_NOT_FOUND;
            o_last_nxt   = 1'b1;
          end
        endcase
      end
      mrte_pkg::S_RESP: begin
        state_nxt    = mrte_pkg::S_IDLE;
        o_strobe_nxt = 1'b1;
        o_status_nxt = rsp_status_r;
        o_addr_nxt   = rd.dest;
        o_nh_nxt     = rd.hop;
        o_hops_nxt   = rd.hops;
        o_seq_nxt    = rd.seq;
        o_iface_nxt  = rd.iface;
        o_valid_nxt  = rd.flags[mrte_pkg::FlValid];
        o_last_nxt   = 1'b1;
      end
      mrte_pkg::S_SWEEP: begin
        wr_idx = cnt_r;
        if (expired) begin
          o_strobe_nxt = 1'b1;
          o_addr_nxt   = rd.dest;
          o_nh_nxt     = rd.hop;
          o_hops_nxt   = rd.hops;
          o_seq_nxt    = rd.seq;
          o_iface_nxt  = rd.iface;
          o_valid_nxt  = rd.flags[mrte_pkg::FlValid];
          if (!rd.flags[mrte_pkg::FlValid]) begin
            o_event_nxt = mrte_pkg::EV_REMOVED;
            wr.op       = mrte_pkg::WR_FREE;
          end else if (rd.hop == rd.dest) begin
            o_event_nxt = mrte_pkg::EV_NBR_BRK;
          end else begin
            o_event_nxt = mrte_pkg::EV_EXPIRED;
          end
        end
        if (cnt_r == IdxW'(TABLE_ENTRIES - 1)) begin
          state_nxt = mrte_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r + IdxW'(1);
        end
      end
      mrte_pkg::S_FIN: begin
        state_nxt    = mrte_pkg::S_IDLE;
        o_strobe_nxt = 1'b1;
        o_last_nxt   = 1'b1;
      end
      default: state_nxt = mrte_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mrte_pkg::S_IDLE;
      o_strobe_r <= 1'b0;
      timeout_r  <= mrte_pkg::TimeoutReset;
    end else begin
      state_r    <= state_nxt;
      o_strobe_r <= o_strobe_nxt;
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
    end
  end

  // Request latch and result payload.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r  <= in_req_type;
      addr_r <= in_dst_addr;
      nh_r   <= in_relay_addr;
      hc_r   <= in_hop_count;
      seq_r  <= in_seq_num;
      ifc_r  <= in_iface;
      now_r  <= in_now;
    end
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    rsp_status_r <= rsp_status_nxt;
    o_status_r   <= o_status_nxt;
    o_event_r    <= o_event_nxt;
    o_addr_r     <= o_addr_nxt;
    o_nh_r       <= o_nh_nxt;
    o_hops_r     <= o_hops_nxt;
    o_seq_r      <= o_seq_nxt;
    o_iface_r    <= o_iface_nxt;
    o_valid_r    <= o_valid_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_strobe         = o_strobe_r;
  assign out_status         = o_status_r;
  assign out_event_res      = o_event_r;
  assign out_route_addr     = o_addr_r;
  assign out_route_relay    = o_nh_r;
  assign out_route_hops     = o_hops_r;
  assign out_route_seq      = o_seq_r;
  assign out_route_iface    = o_iface_r;
  assign out_route_is_valid = o_valid_r;
  assign out_last           = o_last_r;

  // A result beat only follows a cycle of work on a request.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a request in progress");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A removed entry is always reported as invalid.
  a_removed_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_event_res == mrte_pkg::EV_REMOVED) |-> !out_route_is_valid)
    else $error("removed entry reported valid");

  // The closing beat carries no sweep event.
  a_last_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (out_event_res == mrte_pkg::EV_NONE))
    else $error("final beat carries an event");

endmodule

[sv/mrte_cell.sv]
`timescale 1ns / 1ps

module mrte_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mrte_pkg::AddrW-1:0]      key,
  input  mrte_pkg::cell_wr_t              wr,
  input  logic                            sel,
  input  mrte_pkg::chain_t                chain_in,
  output mrte_pkg::chain_t                chain_out,
  output logic                            hit_sel,
  output logic                            free_sel,
  output mrte_pkg::cell_data_t            data
);

  logic                             used_r;
  logic                             used_nxt;
  logic [mrte_pkg::AddrW-1:0]       dest_r;
  logic [mrte_pkg::AddrW-1:0]       hop_r;
  logic [mrte_pkg::SeqW-1:0]        seq_r;
  logic [mrte_pkg::HopsW-1:0]       hops_r;
  logic [mrte_pkg::IfaceW-1:0]      iface_r;
  logic [mrte_pkg::TimeW-1:0]       expiry_r;
  logic [mrte_pkg::FlagW-1:0]       flags_r;
  logic                             hit;

  // Match against the key and claim priority if no lower cell has.
  assign hit                  = used_r && (dest_r == key);
  assign hit_sel              = hit && !chain_in.hit_found;
  assign free_sel             = !used_r && !chain_in.free_found;
  assign chain_out.hit_found  = chain_in.hit_found || hit;
  assign chain_out.free_found = chain_in.free_found || !used_r;

  assign data = '{used: used_r, dest: dest_r, hop: hop_r, seq: seq_r, hops: hops_r,
                  iface: iface_r, expiry: expiry_r, flags: flags_r};

  // Occupancy flag.
  always_comb begin
    used_nxt = used_r;
    if (sel) begin
      case (wr.op)
        mrte_pkg::WR_FULL: used_nxt = 1'b1;
        mrte_pkg::WR_FREE: used_nxt = 1'b0;
        default:           used_nxt = used_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (sel && wr.op == mrte_pkg::WR_FULL) begin
      dest_r  <= wr.dest;
      hop_r   <= wr.hop;
      seq_r   <= wr.seq;
      hops_r  <= wr.hops;
      iface_r <= wr.iface;
      flags_r <= wr.flags;
    end
    if (sel && (wr.op == mrte_pkg::WR_FULL || wr.op == mrte_pkg::WR_LIFE)) begin
      expiry_r <= wr.expiry;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int Entries = mrte_pkg::TableEntriesDef;
  localparam int KeyPool = 40;
  localparam logic [2:0] ReqFirstUnknown = 3'd5;
  localparam logic [2:0] ReqLastUnknown = 3'd7;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  // One result beat as the block should present it.
  typedef struct {
    mrte_pkg::status_t st;
    mrte_pkg::event_t  ev;
    logic [31:0] addr;
    logic [31:0] nh;
    logic [7:0]  hops;
    logic [31:0] seq;
    logic [3:0]  iface;
    logic        vld;
    logic        last;
  } route_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [31:0] in_dst_addr = '0;
  logic [31:0] in_relay_addr = '0;
  logic [7:0] in_hop_count = '0;
  logic [31:0] in_seq_num = '0;
  logic [3:0] in_iface = '0;
  logic [47:0] in_now = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic [1:0] out_event_res;
  logic [31:0] out_route_addr;
  logic [31:0] out_route_relay;
  logic [7:0] out_route_hops;
  logic [31:0] out_route_seq;
  logic [3:0] out_route_iface;
  logic out_route_is_valid;
  logic out_last;

  // Shadow copy of the route table and the timeout register.
  logic [31:0] route_timeout = mrte_pkg::TimeoutReset;
  logic        tbl_used [Entries];
  logic [31:0] tbl_dest [Entries];
  logic [31:0] tbl_hop [Entries];
  logic [31:0] tbl_seq [Entries];
  logic [7:0]  tbl_hops [Entries];
  logic [3:0]  tbl_iface [Entries];
  logic [47:0] tbl_expiry [Entries];
  logic [2:0]  tbl_flags [Entries];

  route_beat_t pending_beats[$];
  int errors = 0;
  bit gaps_on = 1'b1;

  mesh_route_table_engine_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_dst_addr(in_dst_addr),
    .in_relay_addr(in_relay_addr),
    .in_hop_count(in_hop_count),
    .in_seq_num(in_seq_num),
    .in_iface(in_iface),
    .in_now(in_now),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_event_res(out_event_res),
    .out_route_addr(out_route_addr),
    .out_route_relay(out_route_relay),
    .out_route_hops(out_route_hops),
    .out_route_seq(out_route_seq),
    .out_route_iface(out_route_iface),
    .out_route_is_valid(out_route_is_valid),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < Entries; i++) tbl_used[i] = 1'b0;
  end

  function automatic int find_route(input logic [31:0] a);
    for (int i = 0; i < Entries; i++)
      if (tbl_used[i] && tbl_dest[i] == a) return i;
    return -1;
  endfunction

  function automatic int free_route();
    for (int i = 0; i < Entries; i++)
      if (!tbl_used[i]) return i;
    return -1;
  endfunction

  // Beat that reports the stored contents of one slot.
  function automatic route_beat_t slot_beat(input int s, input mrte_pkg::status_t st,
                                            input mrte_pkg::event_t ev, input logic last);
    route_beat_t b;
    b.st = st;
    b.ev = ev;
    b.addr = tbl_dest[s];
    b.nh = tbl_hop[s];
    b.hops = tbl_hops[s];
    b.seq = tbl_seq[s];
    b.iface = tbl_iface[s];
    b.vld = tbl_flags[s][mrte_pkg::FlValid];
    b.last = last;
    return b;
  endfunction

  // Beat that names only an address, with all route fields clear.
  function automatic route_beat_t bare_beat(input mrte_pkg::status_t st,
                                            input logic [31:0] a);
    route_beat_t b;
    b.st = st;
    b.ev = mrte_pkg::EV_NONE;
    b.addr = a;
    b.nh = '0;
    b.hops = '0;
    b.seq = '0;
    b.iface = '0;
    b.vld = 1'b0;
    b.last = 1'b1;
    return b;
  endfunction

  // Apply one accepted request to the shadow table and queue the beats it causes.
  task automatic predict_route_request(input logic [2:0] rq, input logic [31:0] a,
                                       input logic [31:0] nh, input logic [7:0] hc,
                                       input logic [31:0] sq, input logic [3:0] ifc,
                                       input logic [47:0] tn);
    int s;
    logic take;
    logic [48:0] life;
    logic [31:0] d;
    s = find_route(a);
    case (rq) inside
      mrte_pkg::REQ_UPDATE: begin
        life = {1'b0, tn} + {17'b0, route_timeout};
        if (life[48]) life = {1'b0, TimeMax};
        take = 1'b1;
        if (s >= 0) begin
          d = sq - tbl_seq[s];
          take = !tbl_flags[s][mrte_pkg::FlValid] || !tbl_flags[s][mrte_pkg::FlSeqOk] ||
                 (d != 0 && d < 32'h8000_0000) || (d == 0 && hc < tbl_hops[s]);
        end else begin
          s = free_route();
          if (s >= 0) begin
            tbl_used[s] = 1'b1;
            tbl_dest[s] = a;
            tbl_flags[s] = '0;
          end
        end
        if (s < 0) begin
          pending_beats.push_back(bare_beat(mrte_pkg::ST_FULL, a));
        end else begin
          if (take) begin
            tbl_seq[s] = sq;
            tbl_hop[s] = nh;
            tbl_hops[s] = hc;
            tbl_iface[s] = ifc;
            tbl_flags[s] = (tbl_flags[s] & (3'b1 << mrte_pkg::FlStatic)) |
                           (3'b1 << mrte_pkg::FlValid) | (3'b1 << mrte_pkg::FlSeqOk);
          end
          tbl_expiry[s] = life[47:0];
          pending_beats.push_back(slot_beat(s, take ? mrte_pkg::ST_OK : mrte_pkg::ST_LIFE_ONLY,
                                            mrte_pkg::EV_NONE, 1'b1));
        end
      end
      mrte_pkg::REQ_LOOKUP, mrte_pkg::REQ_DELETE: begin
        if (s < 0) begin
          pending_beats.push_back(bare_beat(mrte_pkg::ST_NOT_FOUND, a));
        end else begin
          pending_beats.push_back(slot_beat(s, mrte_pkg::ST_OK, mrte_pkg::EV_NONE, 1'b1));
          if (rq == mrte_pkg::REQ_DELETE) tbl_used[s] = 1'b0;
        end
      end
      mrte_pkg::REQ_STATIC: begin
        if (s < 0) s = free_route();
        if (s < 0) begin
          pending_beats.push_back(bare_beat(mrte_pkg::ST_FULL, a));
        end else begin
          tbl_used[s] = 1'b1;
          tbl_dest[s] = a;
          tbl_seq[s] = 32'd1;
          tbl_hops[s] = '0;
          tbl_hop[s] = a;
          tbl_iface[s] = ifc;
          tbl_expiry[s] = TimeMax;
          tbl_flags[s] = (3'b1 << mrte_pkg::FlValid) | (3'b1 << mrte_pkg::FlSeqOk) |
                         (3'b1 << mrte_pkg::FlStatic);
          pending_beats.push_back(slot_beat(s, mrte_pkg::ST_OK, mrte_pkg::EV_NONE, 1'b1));
        end
      end
      mrte_pkg::REQ_SWEEP: begin
        // Expired non-static routes in slot order, then the closing beat.
        for (int i = 0; i < Entries; i++) begin
          if (!tbl_used[i] || tbl_flags[i][mrte_pkg::FlStatic] || !(tbl_expiry[i] < tn))
            continue;
          if (!tbl_flags[i][mrte_pkg::FlValid]) begin
            pending_beats.push_back(slot_beat(i, mrte_pkg::ST_OK, mrte_pkg::EV_REMOVED, 1'b0));
            tbl_used[i] = 1'b0;
          end else begin
            pending_beats.push_back(slot_beat(i, mrte_pkg::ST_OK,
                                    tbl_hop[i] == tbl_dest[i] ? mrte_pkg::EV_NBR_BRK :
                                                                mrte_pkg::EV_EXPIRED, 1'b0));
          end
        end
        pending_beats.push_back(bare_beat(mrte_pkg::ST_OK, '0));
      end
      default: pending_beats.push_back(bare_beat(mrte_pkg::ST_NOT_FOUND, '0));
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Every strobed beat is checked against the oldest expected one.
  always @(posedge clk) begin
    route_beat_t e;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_beats.size() == 0) begin
        report("unexpected beat", out_route_addr, '0);
      end else begin
        e = pending_beats.pop_front();
        if (out_status !== e.st) report("status", out_status, e.st);
        if (out_event_res !== e.ev) report("event", out_event_res, e.ev);
        if (out_route_addr !== e.addr) report("route_addr", out_route_addr, e.addr);
        if (out_route_relay !== e.nh) report("route_relay", out_route_relay, e.nh);
        if (out_route_hops !== e.hops) report("hops", out_route_hops, e.hops);
        if (out_route_seq !== e.seq) report("seq", out_route_seq, e.seq);
        if (out_route_iface !== e.iface) report("iface", out_route_iface, e.iface);
        if (out_route_is_valid !== e.vld) report("is_valid", out_route_is_valid, e.vld);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one request beat and hold it until the block takes it.
  task automatic send(input logic [2:0] rq, input logic [31:0] a, input logic [31:0] nh,
                      input logic [7:0] hc, input logic [31:0] sq, input logic [3:0] ifc,
                      input logic [47:0] tn);
    if (gaps_on && $urandom_range(0, 99) < 10) idle($urandom_range(1, 6));
    in_req_type <= rq;
    in_dst_addr <= a;
    in_relay_addr <= nh;
    in_hop_count <= hc;
    in_seq_num <= sq;
    in_iface <= ifc;
    in_now <= tn;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_route_request(rq, a, nh, hc, sq, ifc, tn);
  endtask

  // Wait until every expected beat is in, then let a sweep's worth of cycles pass.
  task automatic drain();
    idle(1);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (Entries + 8) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    route_timeout = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Replacement rules, sequence wrap, statics, unknown requests and sweep events.
  task automatic test_directed_ops();
    logic [31:0] a_ones, c_addr, s_addr;
    a_ones = 32'hFFFF_FFFF;
    c_addr = 32'hA5A5_5A5A;
    s_addr = 32'h1234_5678;
    send(mrte_pkg::REQ_LOOKUP, a_ones, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_DELETE, a_ones, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_UPDATE, a_ones, '0, 8'hFF, 32'hFFFF_FFFF, 4'hF, TimeMax);
    send(mrte_pkg::REQ_UPDATE, a_ones, 32'h1, 8'hFE, 32'hFFFF_FFFF, 4'h3, 48'd10);
    send(mrte_pkg::REQ_UPDATE, a_ones, 32'h2, 8'hFF, 32'hFFFF_FFFF, 4'h4, 48'd20);
    send(mrte_pkg::REQ_UPDATE, a_ones, 32'h3, 8'h40, 32'h0, 4'h5, 48'd30);
    send(mrte_pkg::REQ_UPDATE, a_ones, 32'h4, 8'h01, 32'h8000_0000, 4'h6, 48'd40);
    send(mrte_pkg::REQ_LOOKUP, a_ones, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_UPDATE, 32'h0, 32'h0, 8'h0, 32'h0, 4'h0, 48'd0);
    send(ReqFirstUnknown, 32'h55, 32'h66, 8'h7, 32'h8, 4'h9, 48'd1);
    send(ReqLastUnknown, a_ones, a_ones, 8'hFF, a_ones, 4'hF, TimeMax);
    send(mrte_pkg::REQ_STATIC, s_addr, '0, '0, '0, 4'h9, 48'd0);
    send(mrte_pkg::REQ_UPDATE, s_addr, 32'hCAFE_0001, 8'h3, 32'h5, 4'h2, 48'd0);
    send(mrte_pkg::REQ_STATIC, a_ones, '0, '0, '0, 4'hA, 48'd50);
    send(mrte_pkg::REQ_SWEEP, '0, '0, '0, '0, '0, 48'h0000_0001_0000);
    send(mrte_pkg::REQ_UPDATE, c_addr, 32'h0BAD_F00D, 8'h5, 32'h77, 4'h1, 48'd0);
    send(mrte_pkg::REQ_SWEEP, '0, '0, '0, '0, '0, 48'd5000);
    send(mrte_pkg::REQ_DELETE, a_ones, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_DELETE, 32'h0, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_DELETE, c_addr, '0, '0, '0, '0, '0);
    send(mrte_pkg::REQ_DELETE, s_addr, '0, '0, '0, '0, '0);
  endtask

  // Fill every slot, then try to add one more route each way.
  task automatic test_table_full();
    for (int i = 0; i < Entries; i++)
      send(i[0] ? mrte_pkg::REQ_STATIC : mrte_pkg::REQ_UPDATE, 32'h100 + i, 32'h200 + i,
           i[7:0], i, i[3:0], 48'd0);
    send(mrte_pkg::REQ_UPDATE, 32'hDEAD_BEEF, 32'h1, 8'h1, 32'h1, 4'h1, 48'd0);
    send(mrte_pkg::REQ_STATIC, 32'hDEAD_BEEF, '0, '0, '0, 4'h2, 48'd0);
    for (int i = 0; i < Entries; i++)
      send(mrte_pkg::REQ_DELETE, 32'h100 + i, '0, '0, '0, '0, '0);
  endtask

  // Timeout extremes: saturation at the top, expiry one tick after an update.
  task automatic test_timeout_extremes();
    write_timeout(32'hFFFF_FFFF);
    send(mrte_pkg::REQ_UPDATE, 32'h31, 32'h31, 8'h2, 32'h9, 4'h1, TimeMax - 48'd5);
    send(mrte_pkg::REQ_UPDATE, 32'h32, 32'h99, 8'h2, 32'h9, 4'h1, 48'd0);
    send(mrte_pkg::REQ_SWEEP, '0, '0, '0, '0, '0, TimeMax);
    write_timeout(32'd1);
    send(mrte_pkg::REQ_UPDATE, 32'h33, 32'h33, 8'h2, 32'h9, 4'h1, 48'd100);
    send(mrte_pkg::REQ_SWEEP, '0, '0, '0, '0, '0, 48'd101);
    send(mrte_pkg::REQ_SWEEP, '0, '0, '0, '0, '0, 48'd102);
    for (int i = 1; i <= 3; i++)
      send(mrte_pkg::REQ_DELETE, 32'h30 + i, '0, '0, '0, '0, '0);
  endtask

  // Random traffic on a key pool larger than the table, so it fills and churns.
  task automatic test_random_traffic(input int n, input logic [31:0] tmo);
    logic [31:0] keys [KeyPool];
    logic [31:0] key_seq [KeyPool];
    logic [47:0] tnow;
    logic [2:0] rq;
    logic [31:0] a, nh, sq;
    logic [7:0] hc;
    int k, pick;
    write_timeout(tmo);
    for (int i = 0; i < KeyPool; i++) begin
      keys[i] = $urandom;
      key_seq[i] = $urandom;
    end
    tnow = {16'($urandom_range(0, 16'hFFFE)), $urandom};
    for (int it = 0; it < n; it++) begin
      gaps_on = !(it >= n / 3 && it < n / 2);
      if (it == (2 * n) / 3) drain();
      k = $urandom_range(0, KeyPool - 1);
      a = keys[k];
      nh = $urandom_range(0, 1) ? a : $urandom;
      hc = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
      sq = $urandom_range(0, 7) == 0 ? $urandom : key_seq[k] + $urandom_range(0, 3) - 1;
      tnow = tnow + $urandom_range(0, tmo / 4 + 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) rq = mrte_pkg::REQ_UPDATE;
      else if (pick < 60) rq = mrte_pkg::REQ_LOOKUP;
      else if (pick < 72) rq = mrte_pkg::REQ_DELETE;
      else if (pick < 77) rq = mrte_pkg::REQ_STATIC;
      else if (pick < 95) rq = mrte_pkg::REQ_SWEEP;
      else rq = 3'($urandom_range(ReqFirstUnknown, ReqLastUnknown));
      send(rq, a, nh, hc, sq, 4'($urandom_range(0, 15)),
           $urandom_range(0, 29) == 0 ? 48'({$urandom, $urandom}) : tnow);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_table_full();
    test_timeout_extremes();
    test_random_traffic(20, 32'd300);
    test_random_traffic(14, 32'd40);
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/mrte_pkg.sv
sv/mrte_cell.sv
sv/mesh_route_table_engine_top.sv
test/testbench.sv
